// ===== hdl/izz_pkg.sv =====
// ----------------------------------------------------------------------------
// izz_pkg
// Shared constants and types for the ZZ Ising ground-energy search block.
// ----------------------------------------------------------------------------
package izz_pkg;

  localparam int MAX_QUBITS = 20;
  localparam int MAX_TERMS  = 64;

  localparam int MASK_W  = 20;
  localparam int COEFF_W = 32;
  localparam int QC_W    = 5;
  localparam int OUT_W   = 39;

  localparam int TERM_W = MASK_W + COEFF_W;
  localparam int IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int QW     = MAX_QUBITS;
  localparam int ACC_W  = COEFF_W + CNT_W;

  localparam int IN_TDATA_W  = ((TERM_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Search launch request from the load side.
  typedef struct packed {
    logic              go;
    logic [CNT_W-1:0]  n_terms;
    logic [QC_W-1:0]   qubits;
  } izz_start_t;

endpackage

// ===== hdl/izz_ram.sv =====
// ----------------------------------------------------------------------------
// izz_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module izz_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/izz_search.sv =====
// ----------------------------------------------------------------------------
// izz_search
// Search engine: sweeps basis states and terms through the term store, one
// term read per cycle, accumulates each state's energy and keeps the minimum.
// ----------------------------------------------------------------------------
module izz_search (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  izz_pkg::izz_start_t        start_i,
  output logic                       rd_en_o,
  output logic [izz_pkg::IDX_W-1:0]  rd_addr_o,
  input  logic [izz_pkg::TERM_W-1:0] rd_data_i,
  output logic                       done_o,
  output logic [izz_pkg::ACC_W-1:0]  best_o
);
  import izz_pkg::*;

  // Issue stage
  logic             issue_q, issue_d;
  logic [IDX_W-1:0] t_q, t_d;
  logic [QW-1:0]    i_q, i_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [QW-1:0]    smax_q, smax_d;
  logic             term_end, state_end;

  // Read-data stage tags
  logic             v1_q, first1_q, last1_q, fin1_q;
  logic [QW-1:0]    st1_q;

  // Accumulate and compare stages
  logic signed [ACC_W-1:0]   acc_q, acc_d, base, addend;
  logic signed [COEFF_W-1:0] coeff;
  logic [MASK_W-1:0]         mask, st_ext;
  logic                      odd;
  logic                      cv_q, cfin_q;
  logic signed [ACC_W-1:0]   best_q;
  logic                      have_q, done_q;

  assign term_end  = ({{(CNT_W-IDX_W){1'b0}}, t_q} == (n_q - CNT_W'(1)));
  assign state_end = (i_q == smax_q);

  always_comb begin
    issue_d = issue_q;
    t_d     = t_q;
    i_d     = i_q;
    n_d     = n_q;
    smax_d  = smax_q;
    if (start_i.go) begin
      issue_d = 1'b1;
      t_d     = '0;
      i_d     = '0;
      n_d     = start_i.n_terms;
      for (int b = 0; b < QW; b++) begin
        smax_d[b] = (b < int'(start_i.qubits));
      end
    end else if (issue_q) begin
      if (term_end) begin
        t_d = '0;
        if (state_end) begin
          issue_d = 1'b0;
        end else begin
          i_d = i_q + QW'(1);
        end
      end else begin
        t_d = t_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      t_q     <= '0;
      i_q     <= '0;
      n_q     <= '0;
      smax_q  <= '0;
    end else begin
      issue_q <= issue_d;
      t_q     <= t_d;
      i_q     <= i_d;
      n_q     <= n_d;
      smax_q  <= smax_d;
    end
  end

  assign rd_en_o   = issue_q;
  assign rd_addr_o = t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      first1_q <= 1'b0;
      last1_q  <= 1'b0;
      fin1_q   <= 1'b0;
    end else begin
      v1_q     <= issue_q;
      first1_q <= (t_q == '0);
      last1_q  <= term_end;
      fin1_q   <= term_end && state_end;
    end
  end

  always_ff @(posedge clk_i) begin
    st1_q <= i_q;
  end

  // Energy contribution: minus the coefficient on odd overlap parity
  always_comb begin
    mask   = rd_data_i[MASK_W-1:0];
    coeff  = signed'(rd_data_i[TERM_W-1:MASK_W]);
    st_ext = MASK_W'(st1_q);
    odd    = ^(st_ext & mask);
    addend = ACC_W'(coeff);
    base   = first1_q ? '0 : acc_q;
    acc_d  = odd ? (base - addend) : (base + addend);
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q   <= 1'b0;
      cfin_q <= 1'b0;
      have_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cv_q   <= v1_q && last1_q;
      cfin_q <= v1_q && fin1_q;
      done_q <= cv_q && cfin_q;
      if (start_i.go) begin
        have_q <= 1'b0;
      end else if (cv_q) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cv_q && (!have_q || (acc_q < best_q))) begin
      best_q <= acc_q;
    end
  end

  assign done_o = done_q;
  assign best_o = best_q;

endmodule

// ===== hdl/ising_zz_ground_energy_search.sv =====
// ----------------------------------------------------------------------------
// ising_zz_ground_energy_search
// Brute-force ground-state energy of a diagonal ZZ Ising Hamiltonian.
// ----------------------------------------------------------------------------
// Throughput: one term load per cycle, back to back, while s_axis_tready is high.
// Search: the final term starts a search that reads all N stored terms for
//   each of the 2^Q basis states (Q qubits) through the single read port of
//   the term store, and the minimum then moves on to the output register.
// Input is held off (s_axis_tready low) from the final term until the
//   result has moved into the output register.
// Reset clears control, the term count and sets qubit_count to 1; the term
//   store keeps its contents and needs no clearing pass.
module ising_zz_ground_energy_search (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: qubit_count
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [izz_pkg::QC_W-1:0]       cfg_data_i,
  // Term input
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [19:0] term_mask, [51:20] term_coeff, upper bits zero
  input  logic [izz_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tlast,  // last_term
  // Result output
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [38:0] min_energy, upper bit zero
  output logic [izz_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import izz_pkg::*;

  logic [QC_W-1:0]   qc_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              pend_q, pend_d;
  logic              mv_q, mv_d;
  logic [OUT_W-1:0]  mdata_q;
  logic              load_d;
  logic              in_xact, have_room, wr_en;
  izz_start_t        start;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [TERM_W-1:0] rd_data;
  logic              done;
  logic [ACC_W-1:0]  best;

  // The register is always writable; the user writes it only while idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qc_q <= QC_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      qc_q <= cfg_data_i;
    end
  end

  // Load side: store each term at the running count, drop it once full.
  assign s_axis_tready = !busy_q;
  assign in_xact       = s_axis_tvalid && s_axis_tready;
  assign have_room     = (cnt_q < CNT_W'(MAX_TERMS));
  assign wr_en         = in_xact && have_room;

  always_comb begin
    cnt_d         = cnt_q;
    start.go      = 1'b0;
    start.n_terms = have_room ? (cnt_q + CNT_W'(1)) : cnt_q;
    start.qubits  = qc_q;
    if (in_xact) begin
      if (s_axis_tlast) begin
        // Launch the search over every stored term and restart the count
        start.go = 1'b1;
        cnt_d    = '0;
      end else if (have_room) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  izz_ram #(
    .Width (TERM_W),
    .Depth (MAX_TERMS)
  ) u_term_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (s_axis_tdata[TERM_W-1:0]),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  izz_search u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .done_o    (done),
    .best_o    (best)
  );

  // Result hand-off: hold the finished minimum until the output register
  // is free, then release the input side.
  always_comb begin
    busy_d = busy_q;
    pend_d = pend_q;
    mv_d   = mv_q;
    load_d = 1'b0;
    if (start.go) begin
      busy_d = 1'b1;
    end
    if (done) begin
      pend_d = 1'b1;
    end
    if (mv_q && m_axis_tready) begin
      mv_d = 1'b0;
    end
    if (pend_q && (!mv_q || m_axis_tready)) begin
      mv_d   = 1'b1;
      load_d = 1'b1;
      pend_d = 1'b0;
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      mv_q   <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      pend_q <= pend_d;
      mv_q   <= mv_d;
    end
  end

  // Cast the accumulator to the result width (both are 39 bits here)
  always_ff @(posedge clk_i) begin
    if (load_d) begin
      mdata_q <= OUT_W'(signed'(best));
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, mdata_q};

endmodule
